@@ rtl/tlpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpt_pkg: shared definitions for the two-level page table engine
// Geometry of the directory and page tables, operation and status codes,
// and the payload structs of the request and response channels.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  localparam int DIR_ENTRIES    = 1024;
  localparam int TABLE_ENTRIES  = 1024;
  localparam int TABLE_POOL_DEF = 16;

  localparam int DI_W       = $clog2(DIR_ENTRIES);
  localparam int TI_W       = $clog2(TABLE_ENTRIES);
  localparam int DIR_SHIFT  = 22;
  localparam int TAB_SHIFT  = 12;
  localparam int OFFSET_W   = 12;
  localparam int ADDR_W     = 32;
  localparam int FLAGS_W    = 12;

  // Flag bit positions inside map_flags and the entries.
  localparam int BIT_PRESENT = 0;
  localparam int BIT_WRITE   = 1;
  localparam int BIT_USER    = 2;

  localparam logic [1:0] OP_MAP       = 2'd0;
  localparam logic [1:0] OP_UNMAP     = 2'd1;
  localparam logic [1:0] OP_TRANSLATE = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_TABLE    = 2'd1;
  localparam logic [1:0] ST_NOT_PRESENT = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED   = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [ADDR_W-1:0]  virtual_address;
    logic [ADDR_W-1:0]  physical_address;
    logic [FLAGS_W-1:0] map_flags;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] translated_address;
  } out_t;

endpackage

@@ rtl/two_level_page_table_engine.sv @@
// ----------------------------------------------------------------------------
// two_level_page_table_engine
// Directory of page-table pointers plus a pool of page tables, with map,
// unmap and translate operations walked under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Payload
//  in_      request    in_valid / in_stall   tlpt_pkg::in_t
//  out_     response   out_valid / out_stall tlpt_pkg::out_t
//
// Map, unmap, the unused code and a translate that misses in the directory
// go through the synchronous directory read and then the S_EXEC step, where
// the page-table access is made; a translate through a present directory
// entry reads its page-table entry there and forms its response in S_PTE.
// After reset a clearing pass zeroes both stores; in_stall stays high throughout.
// A response sits in an output register, so a new request is taken while the
// previous response is still stalled; a second response waits in the engine.
// ----------------------------------------------------------------------------
module two_level_page_table_engine #(
  parameter int TABLE_POOL = tlpt_pkg::TABLE_POOL_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tlpt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tlpt_pkg::out_t out_data
);

  localparam int SLOT_W      = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int CNT_W       = $clog2(TABLE_POOL + 1);
  localparam int PADDR_W     = SLOT_W + tlpt_pkg::TI_W;
  localparam int POOL_DEPTH  = TABLE_POOL * tlpt_pkg::TABLE_ENTRIES;
  localparam int FRAME_W     = tlpt_pkg::ADDR_W - tlpt_pkg::OFFSET_W;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              user;
    logic              writable;
    logic              present;
  } dent_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_PTE,
    S_RES
  } state_t;

  state_t               state_r, state_nxt;
  tlpt_pkg::in_t        item_r, item_nxt;
  logic [CNT_W-1:0]     next_free_r, next_free_nxt;
  logic [PADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  tlpt_pkg::out_t       res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tlpt_pkg::out_t       out_data_r, out_data_nxt;

  dent_t                dir_mem [tlpt_pkg::DIR_ENTRIES];
  logic [tlpt_pkg::ADDR_W-1:0] pool_mem [POOL_DEPTH];

  dent_t                       dir_q_r;
  logic [tlpt_pkg::ADDR_W-1:0] pool_q_r;

  logic                        accept;
  logic                        out_free;
  logic                        dir_we;
  logic [tlpt_pkg::DI_W-1:0]   dir_wa;
  dent_t                       dir_wd;
  logic                        pool_we;
  logic [PADDR_W-1:0]          pool_wa;
  logic [tlpt_pkg::ADDR_W-1:0] pool_wd;
  logic [tlpt_pkg::DI_W-1:0]   item_di;
  logic [tlpt_pkg::TI_W-1:0]   item_ti;
  logic                        pool_full;
  logic                        alloc;
  dent_t                       new_dent;
  tlpt_pkg::out_t              exec_res;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign item_di   = item_r.virtual_address[tlpt_pkg::DIR_SHIFT +: tlpt_pkg::DI_W];
  assign item_ti   = item_r.virtual_address[tlpt_pkg::TAB_SHIFT +: tlpt_pkg::TI_W];
  assign pool_full = (next_free_r >= CNT_W'(TABLE_POOL));

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    next_free_nxt = next_free_r;
    clr_cnt_nxt   = clr_cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    dir_we        = 1'b0;
    dir_wa        = item_di;
    dir_wd        = dir_q_r;
    pool_we       = 1'b0;
    pool_wa       = {dir_q_r.slot, item_ti};
    pool_wd       = '0;
    alloc         = 1'b0;
    new_dent      = dir_q_r;
    exec_res      = '{status: tlpt_pkg::ST_OK, translated_address: '0};

    // Outcome of the directory step; only acted on in S_EXEC.
    case (item_r.operation)
      tlpt_pkg::OP_MAP: begin
        if (dir_q_r.present) begin
          new_dent.writable = dir_q_r.writable | item_r.map_flags[tlpt_pkg::BIT_WRITE];
          new_dent.user     = dir_q_r.user | item_r.map_flags[tlpt_pkg::BIT_USER];
        end else begin
          new_dent.slot     = next_free_r[SLOT_W-1:0];
          new_dent.writable = item_r.map_flags[tlpt_pkg::BIT_WRITE];
          new_dent.user     = item_r.map_flags[tlpt_pkg::BIT_USER];
          new_dent.present  = 1'b1;
          alloc             = !pool_full;
        end
        if (!dir_q_r.present && pool_full) begin
          exec_res.status = tlpt_pkg::ST_EXHAUSTED;
        end
      end
      tlpt_pkg::OP_UNMAP: begin
        if (!dir_q_r.present) begin
          exec_res.status = tlpt_pkg::ST_NO_TABLE;
        end
      end
      tlpt_pkg::OP_TRANSLATE: begin
        if (!dir_q_r.present) begin
          exec_res.status = tlpt_pkg::ST_NOT_PRESENT;
        end
      end
      default: begin
        exec_res.status = tlpt_pkg::ST_OK;
      end
    endcase

    unique case (state_r)
      S_CLEAR: begin
        pool_we = 1'b1;
        pool_wa = clr_cnt_r;
        pool_wd = '0;
        dir_we  = (clr_cnt_r < PADDR_W'(tlpt_pkg::DIR_ENTRIES));
        dir_wa  = clr_cnt_r[tlpt_pkg::DI_W-1:0];
        dir_wd  = '0;
        if (clr_cnt_r == PADDR_W'(POOL_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + PADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          item_nxt  = in_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (item_r.operation == tlpt_pkg::OP_MAP) begin
          if (dir_q_r.present || alloc) begin
            dir_we  = 1'b1;
            dir_wd  = new_dent;
            pool_we = 1'b1;
            pool_wa = {new_dent.slot, item_ti};
            pool_wd = {item_r.physical_address[tlpt_pkg::ADDR_W-1:tlpt_pkg::OFFSET_W],
                       item_r.map_flags[tlpt_pkg::FLAGS_W-1:1], 1'b1};
          end
          if (alloc) begin
            next_free_nxt = next_free_r + CNT_W'(1);
          end
        end else if (item_r.operation == tlpt_pkg::OP_UNMAP) begin
          pool_we = dir_q_r.present;
          pool_wd = '0;
        end

        if (item_r.operation == tlpt_pkg::OP_TRANSLATE && dir_q_r.present) begin
          state_nxt = S_PTE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = exec_res;
          state_nxt     = S_IDLE;
        end else begin
          res_nxt   = exec_res;
          state_nxt = S_RES;
        end
      end
      S_PTE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pool_q_r[tlpt_pkg::BIT_PRESENT]) begin
            out_data_nxt.status             = tlpt_pkg::ST_OK;
            out_data_nxt.translated_address =
              {pool_q_r[tlpt_pkg::ADDR_W-1 -: FRAME_W],
               item_r.virtual_address[tlpt_pkg::OFFSET_W-1:0]};
          end else begin
            out_data_nxt.status             = tlpt_pkg::ST_NOT_PRESENT;
            out_data_nxt.translated_address = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      S_RES: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      next_free_r <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_free_r <= next_free_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Directory: one write port, one registered read port taken on acceptance.
  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_wa] <= dir_wd;
    end
    if (accept) begin
      dir_q_r <= dir_mem[in_data.virtual_address[tlpt_pkg::DIR_SHIFT +: tlpt_pkg::DI_W]];
    end
  end

  // Page-table pool: the read is only enabled in the directory step, so the
  // entry stays put while a translate response waits on a stalled output.
  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_wa] <= pool_wd;
    end
    if (state_r == S_EXEC) begin
      pool_q_r <= pool_mem[pool_wa];
    end
  end

  // The allocation counter never passes the pool size.
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= CNT_W'(TABLE_POOL))
    else $error("table allocation counter beyond pool size");

  // The counter moves by one exactly when a table is handed out.
  a_free_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && alloc) |=> (next_free_r == $past(next_free_r) + CNT_W'(1)))
    else $error("table allocation did not advance the counter");

  a_free_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == S_EXEC && alloc) |=> $stable(next_free_r))
    else $error("table allocation counter moved without an allocation");

  // An exhausted status is only reported once every table is in use.
  a_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == tlpt_pkg::ST_EXHAUSTED) |->
      (next_free_r == CNT_W'(TABLE_POOL)))
    else $error("pool exhausted reported with free tables left");

  // No transaction is taken while the stores are being cleared.
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (in_stall && !out_valid_r))
    else $error("engine active during the clearing pass");

endmodule
